@@ rtl/core/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks sampled on the rising clock edge and suspended while reset is asserted.
`define DQ_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("deque check failed");

// Checks that also hold while reset is asserted.
`define DQ_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("deque check failed during reset");

`endif

@@ rtl/core/dq_pkg.sv @@
`default_nettype none

package dq_pkg;

    typedef enum logic [1:0] {
        OP_PUSH_FRONT = 2'd0,
        OP_PUSH_BACK  = 2'd1,
        OP_POP_FRONT  = 2'd2,
        OP_POP_BACK   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_READ = 1'b1
    } state_t;

endpackage

`default_nettype wire

@@ rtl/core/dq_ram.sv @@
`default_nettype none

module dq_ram
    import dq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32
)(
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ rtl/core/double_ended_queue.sv @@
// Channel | Direction | Payload (lowest bit first)
// s_*     | in        | func, value
// m_*     | out       | status, count, front_value, back_value
//
// A push or a refused operation is answered straight from the idle state; a successful
// pop passes through the read state, where the ring memory returns the new end.
// The front and back values are cached in registers, so each operation needs at
// most one memory read and one memory write.
// Reset clears the head index, the entry count and the control state; the ring
// memory itself is not cleared and needs no clearing pass.
// A stalled result holds the output register; no new item is taken until it leaves.
`default_nettype none

module double_ended_queue
    import dq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_tvalid,
    output logic      s_tready,
    // func, value
    input  wire logic [((DATA_WIDTH + 2 + 7) / 8) * 8 - 1:0] s_tdata,
    output logic      m_tvalid,
    input  wire logic m_tready,
    // status, count, front_value, back_value
    output logic [((2 * DATA_WIDTH + $clog2(DEPTH + 1) + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int IW     = $clog2(DEPTH);
    localparam int CW     = $clog2(DEPTH + 1);
    localparam int OUT_W  = 2 * DATA_WIDTH + CW + 2;
    localparam int OUT_PW = ((OUT_W + 7) / 8) * 8;

    state_t                state_reg, state_next;
    logic [IW-1:0]         head_reg, head_next;
    logic [CW-1:0]         count_reg, count_next;
    logic [DATA_WIDTH-1:0] front_reg, front_next;
    logic [DATA_WIDTH-1:0] back_reg, back_next;
    logic                  pend_front_reg, pend_front_next;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_PW-1:0]     m_tdata_reg, m_tdata_next;

    op_t                   in_func;
    logic [DATA_WIDTH-1:0] in_value;

    logic                  ram_we;
    logic [IW-1:0]         ram_waddr;
    logic [IW-1:0]         ram_raddr;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [IW-1:0]         head_dec;
    logic [IW-1:0]         head_inc;
    logic [IW-1:0]         tail_slot;
    logic [IW-1:0]         back_prev_slot;

    logic                  res_load;
    status_t               res_status;
    logic [CW-1:0]         res_count;
    logic [DATA_WIDTH-1:0] res_front;
    logic [DATA_WIDTH-1:0] res_back;

    // Slot of base plus offset around the ring; the sum stays below twice the depth for offsets up to the depth.
    function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                               input logic [CW-1:0] off);
        logic [CW:0] sum;
        sum = (CW + 1)'(base) + (CW + 1)'(off);
        if (sum >= (CW + 1)'(DEPTH))
        begin
            sum = sum - (CW + 1)'(DEPTH);
        end
        return sum[IW-1:0];
    endfunction

    assign in_func  = op_t'(s_tdata[1:0]);
    assign in_value = s_tdata[2 +: DATA_WIDTH];

    assign head_dec       = (head_reg == '0) ? IW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc       = (head_reg == IW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign tail_slot      = wrap_add(head_reg, count_reg);
    // Its read data is only used when at least two entries are stored.
    assign back_prev_slot = wrap_add(head_reg, count_reg - CW'(2));

    dq_ram #(
        .DEPTH (DEPTH),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (in_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            head_reg     <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            head_reg     <= head_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        back_reg       <= back_next;
        pend_front_reg <= pend_front_next;
        m_tdata_reg    <= m_tdata_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        front_next      = front_reg;
        back_next       = back_reg;
        pend_front_next = pend_front_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_tdata_next    = m_tdata_reg;
        ram_we          = 1'b0;
        ram_waddr       = head_dec;
        ram_raddr       = head_inc;
        res_load        = 1'b0;
        res_status      = ST_OK;
        res_count       = count_reg;
        res_front       = front_reg;
        res_back        = back_reg;
        s_tready        = (state_reg == S_IDLE) && (!m_tvalid_reg || m_tready);

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    unique case (in_func)
                        OP_PUSH_FRONT, OP_PUSH_BACK:
                        begin
                            res_load = 1'b1;
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_status = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                count_next = count_reg + 1'b1;
                                if (in_func == OP_PUSH_FRONT)
                                begin
                                    ram_waddr  = head_dec;
                                    head_next  = head_dec;
                                    front_next = in_value;
                                    if (count_reg == '0)
                                    begin
                                        back_next = in_value;
                                    end
                                end
                                else
                                begin
                                    ram_waddr = tail_slot;
                                    back_next = in_value;
                                    if (count_reg == '0)
                                    begin
                                        front_next = in_value;
                                    end
                                end
                                res_count = count_next;
                                res_front = front_next;
                                res_back  = back_next;
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK:
                        begin
                            if (count_reg == '0)
                            begin
                                res_load   = 1'b1;
                                res_status = ST_EMPTY;
                                res_front  = '0;
                                res_back   = '0;
                            end
                            else
                            begin
                                // The new end comes from memory in the next cycle.
                                count_next = count_reg - 1'b1;
                                state_next = S_READ;
                                if (in_func == OP_POP_FRONT)
                                begin
                                    head_next       = head_inc;
                                    ram_raddr       = head_inc;
                                    pend_front_next = 1'b1;
                                end
                                else
                                begin
                                    ram_raddr       = back_prev_slot;
                                    pend_front_next = 1'b0;
                                end
                            end
                        end
                        default:
                        begin
                            res_load = 1'b0;
                        end
                    endcase
                end
            end
            S_READ:
            begin
                res_load   = 1'b1;
                state_next = S_IDLE;
                if (count_reg == '0)
                begin
                    res_front = '0;
                    res_back  = '0;
                end
                else if (pend_front_reg)
                begin
                    front_next = ram_rdata;
                    res_front  = ram_rdata;
                end
                else
                begin
                    back_next = ram_rdata;
                    res_back  = ram_rdata;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (res_load)
        begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = OUT_PW'({res_back, res_front, res_count, res_status});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

@@ rtl/core/dq_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module dq_checker
    import dq_pkg::*;
#(
    parameter int DEPTH      = 64,
    parameter int DATA_WIDTH = 32
)(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_tvalid,
    input wire logic s_tready,
    input wire logic m_tvalid,
    input wire logic m_tready,
    input wire logic [((2 * DATA_WIDTH + $clog2(DEPTH + 1) + 2 + 7) / 8) * 8 - 1:0] m_tdata
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [1:0]            out_status;
    logic [CW-1:0]         out_count;
    logic [DATA_WIDTH-1:0] out_front;
    logic [DATA_WIDTH-1:0] out_back;
    logic                  in_seen;
    logic                  empty_res;
    logic                  zero_view;

    assign out_status = m_tdata[1:0];
    assign out_count  = m_tdata[2 +: CW];
    assign out_front  = m_tdata[2 + CW +: DATA_WIDTH];
    assign out_back   = m_tdata[2 + CW + DATA_WIDTH +: DATA_WIDTH];
    assign in_seen    = s_tvalid && s_tready;
    assign empty_res  = m_tvalid && (out_status == ST_EMPTY);
    assign zero_view  = (out_count == '0) && (out_front == '0) && (out_back == '0);

    `DQ_ASSERT(a_result_held, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

    `DQ_ASSERT(a_no_accept_on_stall, m_tvalid && !m_tready |-> !in_seen)

    `DQ_ASSERT(a_empty_reads_zero, empty_res |-> zero_view)

    `DQ_ASSERT(a_full_count, m_tvalid && out_status == ST_FULL |-> out_count == CW'(DEPTH))

    `DQ_ASSERT_ALWAYS(a_idle_in_reset, !rst_n |-> !m_tvalid)

endmodule

bind double_ended_queue dq_checker #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
) u_dq_checker (.*);

`default_nettype wire

@@ verif/dq_result_checker.sv @@
`default_nettype none

module dq_result_checker
    import dq_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IN_W  = 40,
    parameter int OUT_W = 80
)(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    input  wire logic             s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             m_tvalid,
    input  wire logic             m_tready,
    input  wire logic [OUT_W-1:0] m_tdata,
    output int                    mismatches,
    output int                    pending
);

    localparam int SLOT_W  = $clog2(DEPTH);
    localparam int COUNT_W = $clog2(DEPTH + 1);

    typedef struct packed {
        status_t            status;
        logic [COUNT_W-1:0] count;
        logic [31:0]        front_value;
        logic [31:0]        back_value;
    } deque_view_t;

    // Shadow copy of the deque, advanced once per accepted input item.
    logic [31:0]        shadow_ring [DEPTH];
    logic [SLOT_W-1:0]  shadow_head;
    logic [COUNT_W-1:0] shadow_count;
    deque_view_t        awaited_views [$];
    int                 mismatch_total;

    task automatic apply_deque_op(input op_t op, input logic [31:0] value,
                                  output deque_view_t view);
        logic [SLOT_W-1:0] slot;
        view = '0;
        view.status = ST_OK;
        case (op)
            OP_PUSH_FRONT, OP_PUSH_BACK:
                if (shadow_count == COUNT_W'(DEPTH)) begin
                    view.status = ST_FULL;
                end else if (op == OP_PUSH_FRONT) begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_ring[shadow_head] = value;
                    shadow_count = shadow_count + 1'b1;
                end else begin
                    slot = shadow_head + SLOT_W'(shadow_count);
                    shadow_ring[slot] = value;
                    shadow_count = shadow_count + 1'b1;
                end
            default:
                if (shadow_count == '0) begin
                    view.status = ST_EMPTY;
                end else if (op == OP_POP_FRONT) begin
                    shadow_head = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end else begin
                    shadow_count = shadow_count - 1'b1;
                end
        endcase
        view.count = shadow_count;
        if (shadow_count != '0) begin
            // With a full ring the low bits of the count wrap to zero, which
            // still lands the back slot just behind the head.
            slot = shadow_head + SLOT_W'(shadow_count) - 1'b1;
            view.front_value = shadow_ring[shadow_head];
            view.back_value  = shadow_ring[slot];
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] wanted);
        if (mismatch_total < 40)
            $display("MISMATCH %s: got 0x%08h, expected 0x%08h", what, got, wanted);
        mismatch_total++;
    endtask

    always @(posedge clk) begin : watch
        deque_view_t seen;
        deque_view_t wanted;
        deque_view_t fresh;
        if (!rst_n) begin
            shadow_head    = '0;
            shadow_count   = '0;
            mismatch_total = 0;
            awaited_views.delete();
        end else begin
            // A result always belongs to an item taken at an earlier edge, so the
            // comparison goes first.
            if (m_tvalid && m_tready) begin
                seen.status      = status_t'(m_tdata[1:0]);
                seen.count       = m_tdata[2 +: COUNT_W];
                seen.front_value = m_tdata[2 + COUNT_W +: 32];
                seen.back_value  = m_tdata[2 + COUNT_W + 32 +: 32];
                if (awaited_views.size() == 0) begin
                    report_mismatch("result with no item outstanding", m_tdata[31:0], '0);
                end else begin
                    wanted = awaited_views[0];
                    awaited_views.delete(0);
                    if (seen.status != wanted.status)
                        report_mismatch("status", 32'(seen.status), 32'(wanted.status));
                    if (seen.count != wanted.count)
                        report_mismatch("count", 32'(seen.count), 32'(wanted.count));
                    if (seen.front_value != wanted.front_value)
                        report_mismatch("front_value", seen.front_value, wanted.front_value);
                    if (seen.back_value != wanted.back_value)
                        report_mismatch("back_value", seen.back_value, wanted.back_value);
                end
            end
            if (s_tvalid && s_tready) begin
                apply_deque_op(op_t'(s_tdata[1:0]), s_tdata[33:2], fresh);
                awaited_views = {awaited_views, fresh};
            end
        end
        mismatches <= mismatch_total;
        pending    <= awaited_views.size();
    end

endmodule

`default_nettype wire

@@ verif/tb_double_ended_queue.sv @@
`default_nettype none

module tb_double_ended_queue;
    import dq_pkg::*;

    localparam int DEPTH       = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int IN_W        = ((DATA_WIDTH + 2 + 7) / 8) * 8;
    localparam int OUT_W       = ((2 * DATA_WIDTH + $clog2(DEPTH + 1) + 2 + 7) / 8) * 8;
    localparam int ITEM_GOAL   = 1300;
    localparam int CYCLE_LIMIT = 400000;

    logic            clk            = 1'b0;
    logic            rst_n;
    logic            s_tvalid       = 1'b0;
    logic            s_tready;
    // func, value
    logic [IN_W-1:0] s_tdata        = '0;
    logic            m_tvalid;
    logic            m_tready       = 1'b0;
    // status, count, front_value, back_value
    logic [OUT_W-1:0] m_tdata;
    logic            quiet_sender   = 1'b0;
    logic            quiet_receiver = 1'b0;
    int              mismatches;
    int              pending;
    int              cycle_count    = 0;

    always #5 clk = ~clk;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    dq_result_checker #(
        .DEPTH (DEPTH),
        .IN_W  (IN_W),
        .OUT_W (OUT_W)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Result side: a fresh stall is drawn after every accepted result.
    initial begin : drain_results
        int stall;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            stall = quiet_receiver ? 0 : $urandom_range(0, 11);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid) @(posedge clk);
        end
    end

    task automatic send_op(input op_t op, input logic [31:0] value);
        int gap;
        gap = quiet_sender ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_W - 34){1'b0}}, value, op};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // Holds the input side until every outstanding result has been taken.
    task automatic wait_for_drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 15))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom();
        endcase
    endfunction

    initial begin : stimulus
        int sent;
        int block_len;
        int push_pct;
        op_t op;
        rst_n <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Pops on the empty queue, wrap of the head below slot zero, value
        // extremes, draining down to empty and one more refused pop.
        send_op(OP_POP_FRONT, 32'h1234_5678);
        send_op(OP_POP_BACK, 32'hFFFF_FFFF);
        send_op(OP_PUSH_FRONT, 32'h7FFF_FFFF);
        send_op(OP_PUSH_BACK, 32'h8000_0000);
        send_op(OP_PUSH_FRONT, 32'hFFFF_FFFF);
        send_op(OP_PUSH_BACK, 32'h0000_0000);
        send_op(OP_PUSH_FRONT, 32'h0000_0001);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_BACK, 32'h0);
        send_op(OP_PUSH_BACK, 32'hAAAA_AAAA);
        send_op(OP_PUSH_FRONT, 32'h5555_5555);
        send_op(OP_POP_FRONT, 32'h0);
        send_op(OP_POP_BACK, 32'h0);
        wait_for_drain();

        // Each block leans toward filling, draining or neither; the first one
        // fills the ring so that refused pushes show up early.
        sent = 0;
        push_pct = 85;
        block_len = 150;
        while (sent < ITEM_GOAL) begin
            quiet_sender = ($urandom_range(0, 4) == 0);
            quiet_receiver <= ($urandom_range(0, 4) == 0);
            repeat (block_len) begin
                if ($urandom_range(1, 100) <= push_pct)
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                send_op(op, pick_value());
                sent++;
            end
            if ($urandom_range(0, 3) == 0)
                wait_for_drain();
            case ($urandom_range(0, 2))
                0:       push_pct = 80;
                1:       push_pct = 20;
                default: push_pct = 50;
            endcase
            block_len = $urandom_range(40, 140);
        end

        wait_for_drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
